### design/mono_framebuffer_pixel_writer_core_defines.svh
`ifndef MONO_FRAMEBUFFER_PIXEL_WRITER_CORE_DEFINES_SVH
`define MONO_FRAMEBUFFER_PIXEL_WRITER_CORE_DEFINES_SVH

// same-cycle implication, checked out of reset
`define MFPW_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked out of reset
`define MFPW_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

### design/mfpw_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package mfpw_pkg;

  localparam int PANEL_COLUMNS_DEF = 400;
  localparam int PANEL_ROWS_DEF    = 300;

  localparam logic [8:0] PANEL_WIDTH_RST     = 9'd400;
  localparam logic [8:0] PANEL_HEIGHT_RST    = 9'd300;
  localparam logic [7:0] WHITE_THRESHOLD_RST = 8'd80;

  localparam int LUM_R = 38;
  localparam int LUM_G = 75;
  localparam int LUM_B = 15;

  localparam logic [7:0] BYTE_WHITE = 8'hFF;

  localparam logic [1:0] CMD_COLOR  = 2'd0;
  localparam logic [1:0] CMD_DIRECT = 2'd1;
  localparam logic [1:0] CMD_READ   = 2'd2;

  localparam logic [1:0] REG_PANEL_WIDTH     = 2'd0;
  localparam logic [1:0] REG_PANEL_HEIGHT    = 2'd1;
  localparam logic [1:0] REG_WHITE_THRESHOLD = 2'd2;

  typedef enum logic [1:0] {
    OP_NONE,
    OP_WRITE,
    OP_READ,
    OP_READ_ZERO
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [2:0] bit_sel;
    logic       white;
  } pix_ctl_t;

endpackage

`default_nettype wire

### design/mfpw_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module mfpw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 15000,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

### design/mfpw_decode.sv
`timescale 1ns / 1ps
`default_nettype none

module mfpw_decode #(
  parameter int PANEL_COLUMNS = mfpw_pkg::PANEL_COLUMNS_DEF,
  parameter int PANEL_ROWS    = mfpw_pkg::PANEL_ROWS_DEF,
  localparam int COLUMN_PAIRS = PANEL_COLUMNS / 2,
  localparam int ROW_BLOCKS   = PANEL_ROWS / 4,
  localparam int STORE_BYTES  = COLUMN_PAIRS * ROW_BLOCKS,
  localparam int AW           = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1
) (
  input  wire logic [1:0]         command,
  input  wire logic [8:0]         x,
  input  wire logic [8:0]         y,
  input  wire logic [15:0]        color,
  input  wire logic               white,
  input  wire logic [13:0]        byte_index,
  input  wire logic [8:0]         panel_width,
  input  wire logic [8:0]         panel_height,
  input  wire logic [7:0]         white_threshold,
  output mfpw_pkg::pix_ctl_t      ctl,
  output logic      [AW-1:0]      addr
);

  logic [7:0]  r8;
  logic [7:0]  g8;
  logic [7:0]  b8;
  logic [14:0] lum_sum;
  logic        lum_white;
  logic [8:0]  inv_y;
  logic [7:0]  pair;
  logic [6:0]  block;
  logic        in_bounds;
  logic        in_store;
  logic [31:0] wr_lin;
  logic [31:0] rd_lin;

  assign r8 = {color[15:11], 3'b000};
  assign g8 = {color[10:5], 2'b00};
  assign b8 = {color[4:0], 3'b000};

  assign lum_sum = 15'(r8) * 15'(mfpw_pkg::LUM_R)
                 + 15'(g8) * 15'(mfpw_pkg::LUM_G)
                 + 15'(b8) * 15'(mfpw_pkg::LUM_B);
  assign lum_white = (lum_sum[14:7] >= white_threshold);

  assign inv_y = panel_height - 9'd1 - y;
  assign pair  = x[8:1];
  assign block = inv_y[8:2];

  assign in_bounds = (x < panel_width) && (y < panel_height)
                  && (32'(pair) < 32'(COLUMN_PAIRS)) && (32'(block) < 32'(ROW_BLOCKS));
  assign in_store  = (32'(byte_index) < 32'(STORE_BYTES));

  assign wr_lin = 32'(pair) * 32'(ROW_BLOCKS) + 32'(block);
  assign rd_lin = 32'(byte_index);

  always_comb begin
    ctl.op      = mfpw_pkg::OP_NONE;
    ctl.bit_sel = 3'd7 - {inv_y[1:0], x[0]};
    ctl.white   = white;
    addr        = wr_lin[AW-1:0];
    case (command)
      mfpw_pkg::CMD_COLOR: begin
        ctl.white = lum_white;
        ctl.op    = in_bounds ? mfpw_pkg::OP_WRITE : mfpw_pkg::OP_NONE;
      end
      mfpw_pkg::CMD_DIRECT: begin
        ctl.op = in_bounds ? mfpw_pkg::OP_WRITE : mfpw_pkg::OP_NONE;
      end
      mfpw_pkg::CMD_READ: begin
        ctl.op = in_store ? mfpw_pkg::OP_READ : mfpw_pkg::OP_READ_ZERO;
        addr   = in_store ? rd_lin[AW-1:0] : '0;
      end
      default: begin
        ctl.op = mfpw_pkg::OP_NONE;
      end
    endcase
  end

endmodule

`default_nettype wire

### design/mono_framebuffer_pixel_writer_core.sv
// A read passes the s1 and s2 stage registers, then the output register. Throughput:
// one item per cycle unless out_stall or the clearing pass holds the pipe; writes are
// read-modify-write over a one-port-read, one-port-write frame RAM, with the last
// written byte forwarded into the merge stage. Reset: synchronous, active low;
// a clearing pass writes 0xFF to every byte, one byte a cycle, holding in_stall high.
`timescale 1ns / 1ps
`default_nettype none
`include "mono_framebuffer_pixel_writer_core_defines.svh"

module mono_framebuffer_pixel_writer_core #(
  parameter int PANEL_COLUMNS = mfpw_pkg::PANEL_COLUMNS_DEF,
  parameter int PANEL_ROWS    = mfpw_pkg::PANEL_ROWS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  in_command,
  input  wire logic [8:0]  in_x,
  input  wire logic [8:0]  in_y,
  input  wire logic [15:0] in_color,
  input  wire logic        in_white,
  input  wire logic [13:0] in_byte_index,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic      [7:0]  out_byte_data,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [8:0]  cfg_data
);

  localparam int COLUMN_PAIRS = PANEL_COLUMNS / 2;
  localparam int ROW_BLOCKS   = PANEL_ROWS / 4;
  localparam int STORE_BYTES  = COLUMN_PAIRS * ROW_BLOCKS;
  localparam int AW           = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1;
  localparam logic [AW-1:0] LAST_ADDR = AW'(STORE_BYTES - 1);

  logic [8:0] panel_width_r;
  logic [8:0] panel_height_r;
  logic [7:0] white_threshold_r;

  logic          clear_active_r;
  logic [AW-1:0] clr_addr_r;

  mfpw_pkg::pix_ctl_t dec_ctl;
  logic [AW-1:0]      dec_addr;

  logic               s1_valid_r;
  mfpw_pkg::pix_ctl_t s1_ctl_r;
  logic [AW-1:0]      s1_addr_r;
  logic               s2_valid_r;
  mfpw_pkg::pix_ctl_t s2_ctl_r;
  logic [AW-1:0]      s2_addr_r;

  logic          fwd_valid_r;
  logic [AW-1:0] fwd_addr_r;
  logic [7:0]    fwd_data_r;

  logic       out_valid_r;
  logic [7:0] out_byte_data_r;

  logic          advance;
  logic          accept;
  logic [7:0]    ram_rdata;
  logic [7:0]    merged;
  logic [7:0]    bit_mask;
  logic [7:0]    modified;
  logic          pix_write;
  logic          s2_read;
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [7:0]    ram_wdata;

  assign advance  = !out_valid_r || !out_stall;
  assign in_stall = clear_active_r || !advance;
  assign accept   = in_valid && !in_stall;

  mfpw_decode #(
    .PANEL_COLUMNS (PANEL_COLUMNS),
    .PANEL_ROWS    (PANEL_ROWS)
  ) u_decode (
    .command         (in_command),
    .x               (in_x),
    .y               (in_y),
    .color           (in_color),
    .white           (in_white),
    .byte_index      (in_byte_index),
    .panel_width     (panel_width_r),
    .panel_height    (panel_height_r),
    .white_threshold (white_threshold_r),
    .ctl             (dec_ctl),
    .addr            (dec_addr)
  );

  assign merged    = (fwd_valid_r && (fwd_addr_r == s2_addr_r)) ? fwd_data_r : ram_rdata;
  assign bit_mask  = 8'b1 << s2_ctl_r.bit_sel;
  assign modified  = s2_ctl_r.white ? (merged | bit_mask) : (merged & ~bit_mask);
  assign pix_write = advance && s2_valid_r && (s2_ctl_r.op == mfpw_pkg::OP_WRITE);
  assign s2_read   = s2_valid_r
                  && ((s2_ctl_r.op == mfpw_pkg::OP_READ) || (s2_ctl_r.op == mfpw_pkg::OP_READ_ZERO));

  assign ram_we    = clear_active_r || pix_write;
  assign ram_waddr = clear_active_r ? clr_addr_r : s2_addr_r;
  assign ram_wdata = clear_active_r ? mfpw_pkg::BYTE_WHITE : modified;

  mfpw_ram #(
    .WIDTH (8),
    .DEPTH (STORE_BYTES)
  ) u_frame_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (advance),
    .raddr (s1_addr_r),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      panel_width_r     <= mfpw_pkg::PANEL_WIDTH_RST;
      panel_height_r    <= mfpw_pkg::PANEL_HEIGHT_RST;
      white_threshold_r <= mfpw_pkg::WHITE_THRESHOLD_RST;
      clear_active_r    <= 1'b1;
      clr_addr_r        <= '0;
      s1_valid_r        <= 1'b0;
      s2_valid_r        <= 1'b0;
      fwd_valid_r       <= 1'b0;
      out_valid_r       <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          mfpw_pkg::REG_PANEL_WIDTH:     panel_width_r     <= cfg_data;
          mfpw_pkg::REG_PANEL_HEIGHT:    panel_height_r    <= cfg_data;
          mfpw_pkg::REG_WHITE_THRESHOLD: white_threshold_r <= cfg_data[7:0];
          default: begin
          end
        endcase
      end
      if (clear_active_r) begin
        clr_addr_r <= clr_addr_r + AW'(1);
        if (clr_addr_r == LAST_ADDR) begin
          clear_active_r <= 1'b0;
        end
      end
      if (advance) begin
        s1_valid_r  <= accept;
        s2_valid_r  <= s1_valid_r;
        out_valid_r <= s2_read;
      end
      if (pix_write) begin
        fwd_valid_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_ctl_r  <= dec_ctl;
      s1_addr_r <= dec_addr;
      s2_ctl_r  <= s1_ctl_r;
      s2_addr_r <= s1_addr_r;
      if (s2_read) begin
        out_byte_data_r <= (s2_ctl_r.op == mfpw_pkg::OP_READ) ? merged : 8'd0;
      end
    end
    if (pix_write) begin
      fwd_addr_r <= s2_addr_r;
      fwd_data_r <= modified;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_byte_data = out_byte_data_r;

  `MFPW_ASSERT_NOW(a_clear_pipe_empty, clear_active_r, !s1_valid_r && !s2_valid_r, "item in flight during clearing pass")
  `MFPW_ASSERT_NEXT(a_read_reaches_out, advance && s2_read, out_valid_r, "read result lost")
  `MFPW_ASSERT_NEXT(a_clear_ends, clear_active_r && (clr_addr_r == LAST_ADDR), !clear_active_r, "clearing pass overran")
  `MFPW_ASSERT_NOW(a_no_write_while_stalled, !advance, !pix_write, "pixel written while pipeline held")

endmodule

`default_nettype wire
